// ----- rtl/lph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants of the linear probing hash set
// Table geometry, operation and result codes, and the counter update word
// that passes from the probe controller to the counter block.
// ----------------------------------------------------------------------------
package lph_pkg;

   // table geometry (depth must be a power of two: the start slot is the key's low bits)
   localparam int TABLE_DEPTH = 256;
   localparam int KEY_BITS    = 32;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int OCC_BITS    = $clog2(TABLE_DEPTH + 1);

   // port widths of the request and response words
   localparam int REQ_KEY_BITS  = 32;
   localparam int OCC_OUT_BITS  = 9;
   localparam int COUNT_BITS    = 32;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [OCC_BITS-1:0]   occ_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_STATS  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RES_NOT_FOUND = 3'd0,
      RES_FOUND     = 3'd1,
      RES_INSERTED  = 3'd2,
      RES_PRESENT   = 3'd3,
      RES_FULL      = 3'd4,
      RES_STATS     = 3'd5
   } res_type;

   // counter update requests from the controller
   typedef struct packed {
      logic occ_inc;
      logic occ_clr;
      logic hit_inc;
      logic ins_inc;
   } cnt_cmd_type;

endpackage : lph_pkg
`default_nettype wire

// ----- rtl/linear_probe_hash_set.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_set: hash set of keys with linear probing
// Open addressing table; one probe per cycle through a shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_operation and req_key with start high; the word is taken at a
//   clock edge where start is high and busy is low.
//   Lookup and insert walk the table from slot (key low bits), one slot per
//   clock against the registered key memory read port. busy stays high
//   while the walk visits its slots (1 up to the table depth); the response
//   appears in the cycle after the last probe.
//   Clear and statistics read answer in the cycle after the accept, with
//   busy never raised. Clear drops all valid bits at the accepting edge.
//   Each response sits on the rsp_ ports for one cycle with rsp_valid high;
//   the receiver cannot stall it. A new word may be started in the response
//   cycle. A lookup or insert holds off new words until its walk ends;
//   clear and statistics read never do.
//   Reset empties the table and zeroes occupancy and both counters.
// ----------------------------------------------------------------------------
module linear_probe_hash_set (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_key,
   output      logic        rsp_valid,
   output      logic [2:0]  rsp_result_code,
   output      logic [8:0]  rsp_occupied_count,
   output      logic [31:0] rsp_hit_count,
   output      logic [31:0] rsp_insert_count
);
   import lph_pkg::*;

   logic        wr_en;
   idx_type     wr_addr;
   key_type     wr_data;
   idx_type     rd_addr;
   key_type     rd_data;
   cnt_cmd_type cnt_cmd;
   res_type     code;
   occ_type     occupancy;
   count_type   hits;
   count_type   inserts;

   // probe sequencer
   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .op        (op_type'(req_operation)),
      .key       (key_type'(req_key)),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .cnt_cmd   (cnt_cmd),
      .rsp_valid (rsp_valid),
      .rsp_code  (code)
   );

   // key storage
   lph_key_ram u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // occupancy and statistics
   lph_counters u_counters (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cnt_cmd),
      .occupancy (occupancy),
      .hits      (hits),
      .inserts   (inserts)
   );

   // response word
   assign rsp_result_code    = code;
   assign rsp_occupied_count = occupancy[OCC_OUT_BITS-1:0];
   assign rsp_hit_count      = hits;
   assign rsp_insert_count   = inserts;

endmodule : linear_probe_hash_set
`default_nettype wire

// ----- rtl/lph_key_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_key_ram: key storage of the hash table
// One write port and one read port with registered read data. Entries hold
// no reset value; only slots marked valid are ever compared.
// ----------------------------------------------------------------------------
module lph_key_ram (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire lph_pkg::idx_type wr_addr,
   input  wire lph_pkg::key_type wr_data,
   input  wire lph_pkg::idx_type rd_addr,
   output      lph_pkg::key_type rd_data
);
   import lph_pkg::*;

   key_type mem [TABLE_DEPTH];
   key_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : lph_key_ram
`default_nettype wire

// ----- rtl/lph_counters.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_counters: occupancy and statistics counters
// Occupancy counts valid slots; hit and insert counts saturate at all ones.
// ----------------------------------------------------------------------------
module lph_counters (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lph_pkg::cnt_cmd_type cmd,
   output      lph_pkg::occ_type     occupancy,
   output      lph_pkg::count_type   hits,
   output      lph_pkg::count_type   inserts
);
   import lph_pkg::*;

   occ_type   occ_ff,  occ_in;
   count_type hit_ff,  hit_in;
   count_type ins_ff,  ins_in;

   // next values
   always_comb begin
      occ_in = occ_ff;
      hit_in = hit_ff;
      ins_in = ins_ff;
      if (cmd.occ_clr) begin
         occ_in = '0;
      end else if (cmd.occ_inc) begin
         occ_in = occ_ff + occ_type'(1);
      end
      if (cmd.hit_inc && (hit_ff != '1)) begin
         hit_in = hit_ff + count_type'(1);
      end
      if (cmd.ins_inc && (ins_ff != '1)) begin
         ins_in = ins_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         hit_ff <= '0;
         ins_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         hit_ff <= hit_in;
         ins_ff <= ins_in;
      end
   end

   assign occupancy = occ_ff;
   assign hits      = hit_ff;
   assign inserts   = ins_ff;

   // occupancy never passes the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= occ_type'(TABLE_DEPTH))
      else $error("occupancy above table depth");

   // hit count never moves backward outside reset
   a_hit_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hit_ff >= $past(hit_ff))
      else $error("hit count decreased");

endmodule : lph_counters
`default_nettype wire

// ----- rtl/lph_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ctrl: probe sequencer of the hash set
// Takes one command word; lookup and insert walk the table one slot per
// cycle via one key comparator; keeps slot valid bits, emits the response.
// ----------------------------------------------------------------------------
module lph_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire lph_pkg::op_type      op,
   input  wire lph_pkg::key_type     key,
   // key memory
   output      logic                 wr_en,
   output      lph_pkg::idx_type     wr_addr,
   output      lph_pkg::key_type     wr_data,
   output      lph_pkg::idx_type     rd_addr,
   input  wire lph_pkg::key_type     rd_data,
   // counters
   output      lph_pkg::cnt_cmd_type cnt_cmd,
   // response strobe and code
   output      logic                 rsp_valid,
   output      lph_pkg::res_type     rsp_code
);
   import lph_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type             state_ff,  state_in;
   op_type                op_ff,     op_in;
   key_type               key_ff,    key_in;
   idx_type               addr_ff,   addr_in;
   idx_type               cnt_ff,    cnt_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   res_type               code_ff,   code_in;

   logic accept;
   logic slot_used;
   logic key_hit;
   logic last_probe;

   assign accept     = start && (state_ff == ST_IDLE);
   assign slot_used  = valid_ff[addr_ff];
   assign key_hit    = (rd_data == key_ff);
   assign last_probe = (cnt_ff == idx_type'(TABLE_DEPTH - 1));

   // read the start slot on accept, the following slot while probing
   assign rd_addr = (state_ff == ST_PROBE) ? addr_ff + idx_type'(1) : key[IDX_BITS-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      code_in      = code_ff;
      wr_en        = 1'b0;
      cnt_cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = op;
               key_in  = key;
               addr_in = key[IDX_BITS-1:0];
               cnt_in  = '0;
               case (op)
                  OP_LOOKUP: begin
                     state_in = ST_PROBE;
                  end
                  OP_INSERT: begin
                     state_in        = ST_PROBE;
                     cnt_cmd.ins_inc = 1'b1;
                  end
                  OP_CLEAR: begin
                     valid_in        = '0;
                     cnt_cmd.occ_clr = 1'b1;
                     rsp_valid_in    = 1'b1;
                     code_in         = RES_STATS;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     code_in      = RES_STATS;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (!slot_used) begin
               // empty slot ends the walk
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (op_ff == OP_INSERT) begin
                  wr_en             = 1'b1;
                  valid_in[addr_ff] = 1'b1;
                  cnt_cmd.occ_inc   = 1'b1;
                  code_in           = RES_INSERTED;
               end else begin
                  code_in = RES_NOT_FOUND;
               end
            end else if (key_hit) begin
               // matching key ends the walk
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (op_ff == OP_INSERT) begin
                  code_in = RES_PRESENT;
               end else begin
                  cnt_cmd.hit_inc = 1'b1;
                  code_in         = RES_FOUND;
               end
            end else if (last_probe) begin
               // every slot visited
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               code_in      = (op_ff == OP_INSERT) ? RES_FULL : RES_NOT_FOUND;
            end else begin
               addr_in = addr_ff + idx_type'(1);
               cnt_in  = cnt_ff + idx_type'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      code_ff <= code_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign wr_addr   = addr_ff;
   assign wr_data   = key_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = code_ff;

   // a lookup or insert always enters the probe walk
   a_probe_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_LOOKUP || op == OP_INSERT)) |=> state_ff == ST_PROBE)
      else $error("probe walk not entered");

   // a key is only written into an empty slot
   a_write_empty: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[addr_ff])
      else $error("write into an occupied slot");

   // probe outcomes only follow a probe cycle
   a_probe_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (code_ff == RES_FOUND || code_ff == RES_INSERTED ||
                        code_ff == RES_PRESENT || code_ff == RES_FULL))
      |-> $past(state_ff == ST_PROBE))
      else $error("probe result without a probe");

endmodule : lph_ctrl
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for linear_probe_hash_set
// Sends lookup, insert, clear and statistics words in random bursts, keeps a
// shadow copy of the table and counters, and compares every response field
// with the answer the shadow predicts for the oldest outstanding word.
// ----------------------------------------------------------------------------
module testbench;
   import lph_pkg::*;

   localparam int TOTAL_WORDS = 650;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [2:0]  code;
      logic [8:0]  occ;
      logic [31:0] hits;
      logic [31:0] inserts;
   } answer_type;

   // shadow of the hash set: predicts one answer per accepted word
   class hash_set_shadow;
      logic [31:0] slot_key [TABLE_DEPTH];
      bit          slot_used [TABLE_DEPTH];
      int unsigned occupancy;
      logic [31:0] hits;
      logic [31:0] inserts;
      answer_type  answers_due [$];
      int          errors;
      int          checked;
      int          code_seen [6];

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         occupancy = 0;
         hits      = '0;
         inserts   = '0;
         errors    = 0;
         checked   = 0;
         foreach (code_seen[i]) code_seen[i] = 0;
      endfunction

      // walk the probe chain and apply the operation to the shadow state
      function void take_request(op_type op, logic [31:0] key);
         answer_type  a;
         int unsigned base;
         int unsigned p;
         int          hit_at;
         int          free_at;
         hit_at  = -1;
         free_at = -1;
         base    = key % TABLE_DEPTH;
         if (op == OP_LOOKUP || op == OP_INSERT) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               p = (base + i) % TABLE_DEPTH;
               if (!slot_used[p]) begin
                  free_at = p;
                  break;
               end
               if (slot_key[p] == key) begin
                  hit_at = p;
                  break;
               end
            end
         end
         a.code = RES_STATS;
         case (op)
            OP_LOOKUP: begin
               if (hit_at >= 0) begin
                  a.code = RES_FOUND;
                  if (hits != '1) hits++;
               end else begin
                  a.code = RES_NOT_FOUND;
               end
            end
            OP_INSERT: begin
               if (inserts != '1) inserts++;
               if (hit_at >= 0) begin
                  a.code = RES_PRESENT;
               end else if (free_at >= 0) begin
                  slot_used[free_at] = 1'b1;
                  slot_key[free_at]  = key;
                  occupancy++;
                  a.code = RES_INSERTED;
               end else begin
                  a.code = RES_FULL;
               end
            end
            OP_CLEAR: begin
               foreach (slot_used[i]) slot_used[i] = 1'b0;
               occupancy = 0;
            end
            default: ;
         endcase
         a.occ     = 9'(occupancy);
         a.hits    = hits;
         a.inserts = inserts;
         answers_due.push_back(a);
      endfunction

      function void compare(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("tb: %s mismatch at %0t: expected %h, got %h", what, $time, want, got);
         end
      endfunction

      // match one response against the oldest outstanding answer
      function void check_response(logic [2:0] code, logic [8:0] occ,
                                   logic [31:0] hit_cnt, logic [31:0] ins_cnt);
         answer_type a;
         if (answers_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("tb: response at %0t with no word outstanding", $time);
            return;
         end
         a = answers_due.pop_front();
         checked++;
         if (a.code <= RES_STATS) code_seen[a.code]++;
         compare("result_code", 32'(a.code), 32'(code));
         compare("occupied_count", 32'(a.occ), 32'(occ));
         compare("hit_count", a.hits, hit_cnt);
         compare("insert_count", a.inserts, ins_cnt);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [31:0] req_key;
   logic        rsp_valid;
   logic [2:0]  rsp_result_code;
   logic [8:0]  rsp_occupied_count;
   logic [31:0] rsp_hit_count;
   logic [31:0] rsp_insert_count;

   hash_set_shadow shadow;
   logic [31:0]    key_pool [$];
   int             words_sent;
   int             burst_left;

   linear_probe_hash_set uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_result_code    (rsp_result_code),
      .rsp_occupied_count (rsp_occupied_count),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_insert_count   (rsp_insert_count)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor: check responses, then note the word accepted at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            shadow.check_response(rsp_result_code, rsp_occupied_count,
                                  rsp_hit_count, rsp_insert_count);
         if (start && !busy)
            shadow.take_request(op_type'(req_operation), req_key);
      end
   end

   // idle cycles with noise on the ignored request fields
   task automatic rest(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start         <= 1'b0;
         req_operation <= 2'($urandom);
         req_key       <= $urandom;
      end
   endtask

   // send one word, inserting a random gap between bursts
   task automatic issue(input op_type op, input logic [31:0] key);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) rest(gap);
      end
      burst_left--;
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      do @(posedge clock); while (busy);
      words_sent++;
      if (op == OP_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > 64) void'(key_pool.pop_front());
      end
   endtask

   // random, reused, low or high end keys to force chains and wrap-around
   function automatic logic [31:0] pick_key();
      logic [31:0] k;
      k = $urandom;
      case ($urandom_range(0, 3))
         0: ;
         1: k[7:0] = 8'($urandom_range(0, 7));
         2: k[7:0] = 8'($urandom_range(248, 255));
         default: if (key_pool.size() > 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      endcase
      return k;
   endfunction

   // stimulus
   initial begin
      int r;
      shadow        = new();
      words_sent    = 0;
      burst_left    = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_LOOKUP;
      req_key       = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, key extremes, wrap past the last slot, clear
      issue(OP_STATS, 32'hFFFF_FFFF);
      issue(OP_LOOKUP, 32'h0000_0000);
      issue(OP_INSERT, 32'h0000_0000);
      issue(OP_INSERT, 32'hFFFF_FFFF);
      issue(OP_INSERT, 32'h1234_56FF);
      issue(OP_INSERT, 32'hABCD_EFFF);
      issue(OP_LOOKUP, 32'hABCD_EFFF);
      issue(OP_LOOKUP, 32'h0000_00FF);
      issue(OP_INSERT, 32'hFFFF_FFFF);
      issue(OP_LOOKUP, 32'h0000_0000);
      issue(OP_INSERT, 32'h8000_0000);
      issue(OP_LOOKUP, 32'h8000_0000);
      issue(OP_STATS, 32'h0000_0000);
      issue(OP_CLEAR, 32'h5A5A_A5A5);
      issue(OP_LOOKUP, 32'hFFFF_FFFF);
      issue(OP_INSERT, 32'h5555_5500);
      issue(OP_LOOKUP, 32'hAAAA_AAAA);
      issue(OP_CLEAR, 32'h0000_0000);

      // fill the table to the last slot, mixing in lookups of inserted keys
      while (shadow.occupancy < TABLE_DEPTH) begin
         if ($urandom_range(0, 4) == 0 && key_pool.size() > 0)
            issue(OP_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
         else
            issue(OP_INSERT, $urandom);
      end

      // full table: new keys are refused, missing keys walk every slot
      repeat (3) issue(OP_INSERT, $urandom);
      repeat (3) issue(OP_LOOKUP, $urandom);
      repeat (3) issue(OP_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)]);
      repeat (3) issue(OP_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
      issue(OP_STATS, $urandom);
      issue(OP_CLEAR, $urandom);

      // random mix of all operations
      while (words_sent < TOTAL_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            issue(OP_LOOKUP, pick_key());
         else if (r < 80)
            issue(OP_INSERT, pick_key());
         else if (r < 86)
            issue(OP_CLEAR, $urandom);
         else
            issue(OP_STATS, $urandom);
      end
      rest(1);

      // drain
      while (shadow.answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      shadow.errors += shadow.answers_due.size();

      $display("tb: %0d words sent, %0d responses checked", words_sent, shadow.checked);
      $display("tb: found %0d, not found %0d, inserted %0d, present %0d, full %0d",
               shadow.code_seen[RES_FOUND], shadow.code_seen[RES_NOT_FOUND],
               shadow.code_seen[RES_INSERTED], shadow.code_seen[RES_PRESENT],
               shadow.code_seen[RES_FULL]);
      if (shadow.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
